// ===== rtl/rra_pkg.sv =====
`default_nettype none
package rra_pkg;

	localparam int POOL_DEPTH_DEF = 16;
	localparam int ORDER_BITS_DEF = 16;

	localparam int IDX_W    = 4;
	localparam int ORDER_W  = 16;
	localparam int TARGET_W = 16;

	localparam logic [TARGET_W-1:0] TARGET_NONE = '1;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_AUTO    = 2'd1,
		OP_MANUAL  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NONE    = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_BUSY    = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		op_t                        operation;
		logic [IDX_W-1:0]           robot_index;
		logic [ORDER_W-1:0]         order_tag;
		logic signed [TARGET_W-1:0] target_node;
		logic                       start_busy;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   granted_index;
		logic [ORDER_W-1:0] granted_order;
		logic               record_valid;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/rra_if.sv =====
`default_nettype none
interface rra_req_if;
	logic                                       valid;
	logic                                       ready;
	rra_pkg::op_t                               operation;
	logic [rra_pkg::IDX_W-1:0]                  robot_index;
	logic [rra_pkg::ORDER_W-1:0]                order_tag;
	logic signed [rra_pkg::TARGET_W-1:0]        target_node;
	logic                                       start_busy;

	modport source (
		output valid, operation, robot_index, order_tag, target_node, start_busy,
		input  ready
	);
	modport sink (
		input  valid, operation, robot_index, order_tag, target_node, start_busy,
		output ready
	);
endinterface

interface rra_rsp_if;
	logic                        valid;
	logic                        ready;
	rra_pkg::status_t            status;
	logic [rra_pkg::IDX_W-1:0]   granted_index;
	logic [rra_pkg::ORDER_W-1:0] granted_order;
	logic                        record_valid;

	modport source (
		output valid, status, granted_index, granted_order, record_valid,
		input  ready
	);
	modport sink (
		input  valid, status, granted_index, granted_order, record_valid,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/round_robin_robot_assigner.sv =====
// an accepted item waits in the input register, its result in the result
// register; throughput: one item per cycle while rsp.ready does not stall,
// given by one pass through the rotated priority encoder over busy flags
// reset: arst_n empties the pool, clears all busy flags and the pointer,
// and drops both the input and the result register
`default_nettype none
module round_robin_robot_assigner #(
	parameter int POOL_DEPTH = rra_pkg::POOL_DEPTH_DEF,
	parameter int ORDER_BITS = rra_pkg::ORDER_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rra_req_if.sink  req,
	rra_rsp_if.source rsp
);
	import rra_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	logic    fire;

	assign fire      = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.operation   <= req.operation;
			item_s1.robot_index <= req.robot_index;
			item_s1.order_tag   <= req.order_tag;
			item_s1.target_node <= req.target_node;
			item_s1.start_busy  <= req.start_busy;
		end
	end

	rra_pool #(
		.POOL_DEPTH(POOL_DEPTH),
		.ORDER_BITS(ORDER_BITS)
	) u_pool (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.status        = res_s2.status;
	assign rsp.granted_index = res_s2.granted_index;
	assign rsp.granted_order = res_s2.granted_order;
	assign rsp.record_valid  = res_s2.record_valid;

	// input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && !rsp.ready))
		else $error("input stalled without a held result");

	// a record is only produced by a successful grant
	a_record_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.record_valid) |-> (rsp.status == ST_OK))
		else $error("record on a failed request");

	// order is zero outside a grant
	a_order_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.record_valid) |-> (rsp.granted_order == '0))
		else $error("order tag outside a grant");

	// a result transfer with no new item empties the result register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && !fire) |=> !rsp.valid)
		else $error("result repeated after transfer");

endmodule
`default_nettype wire

// ===== rtl/rra_scan.sv =====
`default_nettype none
module rra_scan #(
	parameter int POOL_DEPTH = rra_pkg::POOL_DEPTH_DEF,
	localparam int IW = $clog2(POOL_DEPTH)
) (
	input  wire logic [POOL_DEPTH-1:0] free,
	input  wire logic [IW-1:0]         last,
	output logic                       found,
	output logic [IW-1:0]              index
);
	import rra_pkg::*;

	logic [POOL_DEPTH-1:0] upper;
	logic [IW-1:0]         up_idx;
	logic [IW-1:0]         all_idx;

	always_comb begin
		for (int i = 0; i < POOL_DEPTH; i++) begin
			upper[i] = free[i] && (IW'(i) > last);
		end
	end

	// lowest free index after the pointer, else lowest free overall
	always_comb begin
		up_idx  = '0;
		all_idx = '0;
		for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
			if (upper[i]) begin
				up_idx = IW'(i);
			end
			if (free[i]) begin
				all_idx = IW'(i);
			end
		end
	end

	assign found = |free;
	assign index = (|upper) ? up_idx : all_idx;

endmodule
`default_nettype wire

// ===== rtl/rra_pool.sv =====
`default_nettype none
module rra_pool #(
	parameter int POOL_DEPTH = rra_pkg::POOL_DEPTH_DEF,
	parameter int ORDER_BITS = rra_pkg::ORDER_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire rra_pkg::item_t   item,
	output rra_pkg::result_t      result
);
	import rra_pkg::*;

	localparam int IW = $clog2(POOL_DEPTH);
	localparam int PW = $clog2(POOL_DEPTH + 1);
	localparam int CW = ((PW > IDX_W) ? PW : IDX_W) + 1;
	localparam logic [ORDER_W-1:0] ORDER_MASK = (ORDER_BITS >= ORDER_W) ? '1 :
		ORDER_W'((64'd1 << ORDER_BITS) - 64'd1);

	logic [PW-1:0]         size_q, size_d;
	logic [POOL_DEPTH-1:0] busy_q, busy_d;
	logic [IW-1:0]         last_q, last_d;
	logic [POOL_DEPTH-1:0] held_q, held_d;
	logic [TARGET_W-1:0]   target_q [POOL_DEPTH];
	logic [TARGET_W-1:0]   target_d [POOL_DEPTH];

	logic [POOL_DEPTH-1:0] in_pool;
	logic [POOL_DEPTH-1:0] free;
	logic                  scan_found;
	logic [IW-1:0]         scan_idx;
	logic                  full;
	logic [IW-1:0]         size_idx;
	logic                  known;
	logic [IW-1:0]         ri_idx;
	logic [ORDER_W-1:0]    order;

	always_comb begin
		for (int i = 0; i < POOL_DEPTH; i++) begin
			in_pool[i] = CW'(i) < CW'(size_q);
		end
	end

	assign free     = in_pool & ~busy_q;
	assign full     = size_q == PW'(POOL_DEPTH);
	assign size_idx = IW'(size_q);
	assign known    = CW'(item.robot_index) < CW'(size_q);
	assign ri_idx   = IW'(item.robot_index);
	assign order    = item.order_tag & ORDER_MASK;

	rra_scan #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_scan (
		.free (free),
		.last (last_q),
		.found(scan_found),
		.index(scan_idx)
	);

	always_comb begin
		result   = '0;
		size_d   = size_q;
		busy_d   = busy_q;
		last_d   = last_q;
		held_d   = held_q;
		target_d = target_q;
		unique case (item.operation)
			OP_ADD: begin
				if (full) begin
					result.status = ST_FULL;
				end else begin
					busy_d[size_idx]     = item.start_busy;
					held_d[size_idx]     = 1'b0;
					target_d[size_idx]   = TARGET_NONE;
					last_d               = size_idx;
					size_d               = PW'(size_q + 1'b1);
					result.status        = ST_OK;
					result.granted_index = IDX_W'(size_q);
				end
			end
			OP_AUTO: begin
				if (scan_found) begin
					busy_d[scan_idx]     = 1'b1;
					held_d[scan_idx]     = 1'b1;
					last_d               = scan_idx;
					result.status        = ST_OK;
					result.granted_index = IDX_W'(scan_idx);
					result.granted_order = order;
					result.record_valid  = 1'b1;
				end else begin
					result.status = ST_NONE;
				end
			end
			OP_MANUAL: begin
				result.granted_index = item.robot_index;
				if (!known) begin
					result.status = ST_UNKNOWN;
				end else if (busy_q[ri_idx]) begin
					result.status = ST_BUSY;
				end else begin
					busy_d[ri_idx]       = 1'b1;
					held_d[ri_idx]       = 1'b1;
					target_d[ri_idx]     = item.target_node;
					result.status        = ST_OK;
					result.granted_order = order;
					result.record_valid  = 1'b1;
				end
			end
			OP_RELEASE: begin
				result.granted_index = item.robot_index;
				if (!known) begin
					result.status = ST_UNKNOWN;
				end else begin
					busy_d[ri_idx]   = 1'b0;
					held_d[ri_idx]   = 1'b0;
					target_d[ri_idx] = TARGET_NONE;
					result.status    = ST_OK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			busy_q <= '0;
			last_q <= '0;
			held_q <= '0;
			for (int i = 0; i < POOL_DEPTH; i++) begin
				target_q[i] <= TARGET_NONE;
			end
		end else if (fire) begin
			size_q   <= size_d;
			busy_q   <= busy_d;
			last_q   <= last_d;
			held_q   <= held_d;
			target_q <= target_d;
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
	import rra_pkg::*;

	class assign_scoreboard;
		result_t grant_q[$];
		int unsigned errors;
		int unsigned pool_count;
		logic [POOL_DEPTH_DEF-1:0] busy;
		int unsigned pointer;

		function new();
			errors = 0;
			pool_count = 0;
			busy = '0;
			pointer = 0;
		endfunction

		function int unsigned pending();
			return grant_q.size();
		endfunction

		// next state and expected response for one accepted request
		function void note_request(item_t it);
			result_t r;
			int unsigned cand;
			r = '0;
			r.status = ST_OK;
			case (it.operation)
				OP_ADD: begin
					if (pool_count >= POOL_DEPTH_DEF) begin
						r.status = ST_FULL;
					end else begin
						busy[pool_count] = it.start_busy;
						pointer = pool_count;
						r.granted_index = pool_count[IDX_W-1:0];
						pool_count++;
					end
				end
				OP_AUTO: begin
					r.status = ST_NONE;
					for (int unsigned k = 1; k <= pool_count; k++) begin
						cand = (pointer + k) % pool_count;
						if (!busy[cand]) begin
							busy[cand] = 1'b1;
							pointer = cand;
							r.status = ST_OK;
							r.granted_index = cand[IDX_W-1:0];
							r.granted_order = it.order_tag;
							r.record_valid = 1'b1;
							break;
						end
					end
				end
				default: begin
					r.granted_index = it.robot_index;
					if (it.robot_index >= pool_count) begin
						r.status = ST_UNKNOWN;
					end else if (it.operation == OP_MANUAL) begin
						if (busy[it.robot_index]) begin
							r.status = ST_BUSY;
						end else begin
							busy[it.robot_index] = 1'b1;
							r.granted_order = it.order_tag;
							r.record_valid = 1'b1;
						end
					end else begin
						busy[it.robot_index] = 1'b0;
					end
				end
			endcase
			grant_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (grant_q.size() == 0) begin
				$error("unexpected response transfer: status %0d index %0d",
					got.status, got.granted_index);
				errors++;
				return;
			end
			exp_r = grant_q.pop_front();
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.granted_index !== exp_r.granted_index) begin
				$error("granted_index: expected %0d, got %0d",
					exp_r.granted_index, got.granted_index);
				errors++;
			end
			if (got.granted_order !== exp_r.granted_order) begin
				$error("granted_order: expected %0h, got %0h",
					exp_r.granted_order, got.granted_order);
				errors++;
			end
			if (got.record_valid !== exp_r.record_valid) begin
				$error("record_valid: expected %0b, got %0b",
					exp_r.record_valid, got.record_valid);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	bit long_hold_req;
	assign_scoreboard sb = new();

	rra_req_if req ();
	rra_rsp_if rsp ();

	round_robin_robot_assigner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// sampled once per edge, before the design updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request('{operation: req.operation, robot_index: req.robot_index,
					order_tag: req.order_tag, target_node: req.target_node,
					start_busy: req.start_busy});
			if (rsp.valid && rsp.ready)
				sb.check_result('{status: rsp.status, granted_index: rsp.granted_index,
					granted_order: rsp.granted_order, record_valid: rsp.record_valid});
		end
	end

	// response side back-pressure
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (150) @(posedge clk);
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				stall_left = idle_len();
			end
		end
	end

	function automatic item_t make_item(op_t op, logic [IDX_W-1:0] idx,
			logic [ORDER_W-1:0] tag, logic signed [TARGET_W-1:0] node, logic sb_flag);
		item_t it;
		it.operation = op;
		it.robot_index = idx;
		it.order_tag = tag;
		it.target_node = node;
		it.start_busy = sb_flag;
		return it;
	endfunction

	function automatic item_t random_item();
		int unsigned r;
		int unsigned idx;
		op_t op;
		r = $urandom_range(0, 99);
		if (r < 5)
			op = OP_ADD;
		else if (r < 40)
			op = OP_AUTO;
		else if (r < 70)
			op = OP_MANUAL;
		else
			op = OP_RELEASE;
		if (sb.pool_count > 0 && $urandom_range(0, 99) < 85)
			idx = $urandom_range(0, sb.pool_count - 1);
		else
			idx = $urandom_range(0, 15);
		return make_item(op, idx[IDX_W-1:0], ORDER_W'($urandom_range(0, 65535)),
			TARGET_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = idle_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= it.operation;
		req.robot_index <= it.robot_index;
		req.order_tag <= it.order_tag;
		req.target_node <= it.target_node;
		req.start_busy <= it.start_busy;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	// wait for the clock first so the last transfer has been noted
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_item(random_item());
	endtask

	initial begin
		calm = 1'b0;
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.operation <= OP_ADD;
		req.robot_index <= '0;
		req.order_tag <= '0;
		req.target_node <= '0;
		req.start_busy <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool, busy workers, repeated release, wrap of the pointer
		send_item(make_item(OP_AUTO, 4'd0, 16'h0001, -16'sd1, 1'b0));
		send_item(make_item(OP_MANUAL, 4'd0, 16'h0002, 16'sd5, 1'b0));
		send_item(make_item(OP_RELEASE, 4'd15, 16'h0000, -16'sd1, 1'b0));
		send_item(make_item(OP_ADD, 4'd0, 16'h0000, -16'sd1, 1'b1));
		send_item(make_item(OP_AUTO, 4'd0, 16'h0003, -16'sd1, 1'b0));
		send_item(make_item(OP_MANUAL, 4'd0, 16'h0004, 16'sd7, 1'b0));
		send_item(make_item(OP_RELEASE, 4'd0, 16'h0000, -16'sd1, 1'b0));
		send_item(make_item(OP_RELEASE, 4'd0, 16'h0000, -16'sd1, 1'b0));
		send_item(make_item(OP_AUTO, 4'd0, 16'hFFFF, -16'sd1, 1'b0));
		send_item(make_item(OP_ADD, 4'd0, 16'h0000, -16'sd1, 1'b0));
		send_item(make_item(OP_ADD, 4'd0, 16'h0000, -16'sd1, 1'b0));
		send_item(make_item(OP_MANUAL, 4'd1, 16'h0000, -16'sd1, 1'b0));
		send_item(make_item(OP_MANUAL, 4'd2, 16'h8000, 16'sd32767, 1'b1));
		send_item(make_item(OP_AUTO, 4'd15, 16'h5555, 16'sd0, 1'b1));
		send_item(make_item(OP_RELEASE, 4'd1, 16'hFFFF, 16'sd0, 1'b1));
		send_item(make_item(OP_AUTO, 4'd0, 16'h1234, -16'sd1, 1'b0));
		send_item(make_item(OP_MANUAL, 4'd3, 16'hAAAA, 16'sd100, 1'b0));
		send_item(make_item(OP_ADD, 4'd0, 16'h0000, -16'sd1, 1'b1));
		send_item(make_item(OP_RELEASE, 4'd3, 16'h0000, -16'sd1, 1'b0));
		send_item(make_item(OP_AUTO, 4'd0, 16'h7FFF, -16'sd1, 1'b0));

		send_random(240);

		// stall the response side while requests keep coming
		calm = 1'b1;
		long_hold_req = 1'b1;
		send_random(30);
		calm = 1'b0;
		drain();

		calm = 1'b1;
		send_random(200);
		calm = 1'b0;
		send_random(170);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#1000000;
		$display("tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
